// ----- rtl/core/gbn_pkg.sv -----
`timescale 1ns / 1ps
package gbn_pkg;

	localparam int SEQ_BITS    = 32;
	localparam int SIZE_BITS   = 40;
	localparam int PAY_BITS    = 16;
	localparam int WIN_BITS    = 16;
	localparam int CNT_BITS    = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int ADDR_BITS   = 3;
	localparam int DATA_BITS   = 32;

	localparam logic [PAY_BITS-1:0] PAYLOAD_RESET = PAY_BITS'(1024);

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_DATA  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [1:0] ACK_INFO    = 2'd0;
	localparam logic [1:0] ACK_SUCCESS = 2'd1;
	localparam logic [1:0] ACK_REPEAT  = 2'd2;
	localparam logic [1:0] ACK_DUP     = 2'd3;

	localparam logic [1:0] CMD_NOP   = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_DATA  = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	localparam logic REG_PAYLOAD = 1'b0;

	typedef struct packed {
		logic [1:0]           req_type;
		logic [SEQ_BITS-1:0]  packet_seq;
		logic [WIN_BITS-1:0]  sender_window;
		logic [SIZE_BITS-1:0] file_size;
	} req_t;

	typedef struct packed {
		logic                 ack_valid;
		logic [1:0]           ack_code;
		logic [SEQ_BITS-1:0]  ack_seq;
		logic [PAY_BITS-1:0]  write_bytes;
		logic                 transfer_done;
	} rsp_t;

	typedef struct packed {
		logic [1:0]           kind;
		logic [SEQ_BITS-1:0]  seq;
		logic [WIN_BITS-2:0]  half_window;
		logic [SIZE_BITS-1:0] file_size;
	} cmd_t;

endpackage

// ----- rtl/core/gbn_queue.sv -----
`timescale 1ns / 1ps
module gbn_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/core/gbn_front.sv -----
`timescale 1ns / 1ps
module gbn_front (
	input  gbn_pkg::req_t req,
	output gbn_pkg::cmd_t cmd
);
	import gbn_pkg::*;

	always_comb begin
		cmd.seq         = req.packet_seq;
		cmd.half_window = req.sender_window[WIN_BITS-1:1];
		cmd.file_size   = req.file_size;
		unique case (req.req_type)
			REQ_START: cmd.kind = CMD_START;
			REQ_DATA:  cmd.kind = CMD_DATA;
			REQ_TICK:  cmd.kind = CMD_TICK;
			default:   cmd.kind = CMD_NOP;
		endcase
	end

endmodule

// ----- rtl/core/gbn_exec.sv -----
`timescale 1ns / 1ps
module gbn_exec (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [gbn_pkg::PAY_BITS-1:0]   payload_bytes,
	input  logic                           cmd_valid,
	input  gbn_pkg::cmd_t                  cmd,
	output logic                           cmd_pop,
	input  logic                           rsp_full,
	output logic                           rsp_push,
	output gbn_pkg::rsp_t                  rsp
);
	import gbn_pkg::*;

	localparam logic signed [CNT_BITS-1:0] CNT_MIN = {1'b1, {(CNT_BITS-1){1'b0}}};
	localparam logic signed [CNT_BITS-1:0] CNT_ONE = {{(CNT_BITS-1){1'b0}}, 1'b1};

	logic [SEQ_BITS-1:0]         next_q;
	logic [SIZE_BITS-1:0]        remaining_q;
	logic signed [CNT_BITS-1:0]  counter_q;
	logic                        receiving_q;
	logic                        closed_q;

	logic [SEQ_BITS-1:0]         next_d;
	logic [SIZE_BITS-1:0]        remaining_d;
	logic signed [CNT_BITS-1:0]  counter_d;
	logic                        receiving_d;
	logic                        closed_d;

	logic                        seq_match;
	logic                        seq_old;
	logic                        has_rem;
	logic                        rem_short;
	logic [PAY_BITS-1:0]         chunk;
	logic signed [CNT_BITS-1:0]  cnt_dec;
	logic signed [CNT_BITS-1:0]  cnt_inc;
	logic                        over_half;
	logic [SEQ_BITS-1:0]         next_inc;

	assign cmd_pop  = cmd_valid && !rsp_full;
	assign rsp_push = cmd_pop;

	assign seq_match = (cmd.seq == next_q);
	assign seq_old   = (cmd.seq < next_q);
	assign has_rem   = (remaining_q != '0);
	assign rem_short = (remaining_q <= SIZE_BITS'(payload_bytes));
	assign chunk     = rem_short ? remaining_q[PAY_BITS-1:0] : payload_bytes;
	assign cnt_dec   = (counter_q == CNT_MIN) ? counter_q : counter_q - CNT_ONE;
	assign cnt_inc   = cnt_dec + CNT_ONE;
	assign over_half = $signed({cnt_inc[CNT_BITS-1], cnt_inc})
		> $signed({2'b00, cmd.half_window});
	assign next_inc  = next_q + 1'b1;

	always_comb begin
		next_d      = next_q;
		remaining_d = remaining_q;
		counter_d   = counter_q;
		receiving_d = receiving_q;
		closed_d    = closed_q;
		rsp         = '0;
		unique case (cmd.kind)
			CMD_START: begin
				remaining_d   = cmd.file_size;
				receiving_d   = 1'b1;
				counter_d     = '0;
				next_d        = '0;
				rsp.ack_valid = 1'b1;
				rsp.ack_code  = ACK_INFO;
			end
			CMD_DATA: begin
				counter_d = cnt_dec;
				if (seq_match) begin
					if (has_rem) begin
						rsp.write_bytes = chunk;
						next_d          = next_inc;
						remaining_d     = remaining_q - SIZE_BITS'(chunk);
						counter_d       = cnt_inc;
						if (over_half || rem_short) begin
							rsp.ack_valid = 1'b1;
							rsp.ack_code  = ACK_SUCCESS;
							rsp.ack_seq   = next_inc;
						end
						if (rem_short && !closed_q) begin
							closed_d          = 1'b1;
							rsp.transfer_done = 1'b1;
						end
					end else begin
						rsp.ack_valid = 1'b1;
						rsp.ack_code  = ACK_SUCCESS;
						rsp.ack_seq   = cmd.seq + 1'b1;
						if (!closed_q) begin
							closed_d          = 1'b1;
							rsp.transfer_done = 1'b1;
						end
					end
				end else if (seq_old) begin
					rsp.ack_valid = 1'b1;
					rsp.ack_code  = ACK_REPEAT;
					rsp.ack_seq   = next_q;
				end else begin
					rsp.ack_valid = 1'b1;
					rsp.ack_code  = ACK_DUP;
					rsp.ack_seq   = next_q;
				end
			end
			CMD_TICK: begin
				if (receiving_q) begin
					rsp.ack_valid = 1'b1;
					rsp.ack_code  = ACK_DUP;
					rsp.ack_seq   = next_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q      <= '0;
			remaining_q <= '0;
			counter_q   <= '0;
			receiving_q <= 1'b0;
			closed_q    <= 1'b0;
		end else if (cmd_pop) begin
			next_q      <= next_d;
			remaining_q <= remaining_d;
			counter_q   <= counter_d;
			receiving_q <= receiving_d;
			closed_q    <= closed_d;
		end
	end

`ifndef SYNTH
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_push && rsp.transfer_done |-> !closed_q)
		else $error("transfer_done raised after close");

	a_closed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("closed flag cleared");

	a_write_acked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_push && (rsp.write_bytes != '0) |-> cmd.kind == CMD_DATA && seq_match)
		else $error("bytes written for an out-of-order word");

	a_remaining_falls: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && cmd.kind == CMD_DATA |=> remaining_q <= $past(remaining_q))
		else $error("remaining bytes grew on data");

	a_no_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_push && !rsp.ack_valid |-> rsp.ack_code == ACK_INFO && rsp.ack_seq == '0)
		else $error("ack fields set without ack");
`endif

endmodule

// ----- rtl/core/go_back_n_receiver_ack.sv -----
// A pushed word is registered in the command queue and its result in the result queue.
// Throughput: one word per cycle in and out, unless the result queue is full;
// gbn_exec updates next sequence, byte count and counter from its own registers.
// Command and result queues each hold QUEUE_DEPTH words.
// Reset (arst_n low, asynchronous): queues empty, sequence, byte count and
// counter zero, not receiving, not closed, payload_bytes 1024.
`timescale 1ns / 1ps
module go_back_n_receiver_ack #(
	parameter int QUEUE_DEPTH = gbn_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  gbn_pkg::req_t                   req,
	output logic                            empty,
	input  logic                            pop,
	output gbn_pkg::rsp_t                   rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [gbn_pkg::ADDR_BITS-1:0]   paddr,
	input  logic [gbn_pkg::DATA_BITS-1:0]   pwdata,
	output logic [gbn_pkg::DATA_BITS-1:0]   prdata,
	output logic                            pready
);
	import gbn_pkg::*;

	logic [PAY_BITS-1:0] payload_q;
	logic                cfg_wr;
	cmd_t                cmd_in;
	cmd_t                cmd_out;
	logic                cmd_empty;
	logic                cmd_pop;
	logic                rsp_full;
	logic                rsp_push;
	rsp_t                rsp_in;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[ADDR_BITS-1] == REG_PAYLOAD)
		? DATA_BITS'(payload_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q <= PAYLOAD_RESET;
		end else if (cfg_wr && paddr[ADDR_BITS-1] == REG_PAYLOAD) begin
			payload_q <= pwdata[PAY_BITS-1:0];
		end
	end

	gbn_front u_front (
		.req (req),
		.cmd (cmd_in)
	);

	gbn_queue #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	gbn_exec u_exec (
		.clk           (clk),
		.arst_n        (arst_n),
		.payload_bytes (payload_q),
		.cmd_valid     (!cmd_empty),
		.cmd           (cmd_out),
		.cmd_pop       (cmd_pop),
		.rsp_full      (rsp_full),
		.rsp_push      (rsp_push),
		.rsp           (rsp_in)
	);

	gbn_queue #(
		.WIDTH ($bits(rsp_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_rsp_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rsp_push),
		.wdata  (rsp_in),
		.full   (rsp_full),
		.pop    (pop),
		.rdata  (rsp),
		.empty  (empty)
	);

endmodule

// ----- tb/go_back_n_receiver_ack_test.sv -----
`timescale 1ns / 1ps
module go_back_n_receiver_ack_test;
	import gbn_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;

	class ack_board;
		logic [PAY_BITS-1:0]  payload;
		logic [SEQ_BITS-1:0]  next_seq;
		logic [SIZE_BITS-1:0] bytes_left;
		int                   ack_count;
		logic [WIN_BITS-1:0]  win;
		bit                   receiving;
		bit                   closed;
		rsp_t                 acks_due[$];
		int                   errors;

		function new();
			payload    = PAYLOAD_RESET;
			next_seq   = '0;
			bytes_left = '0;
			ack_count  = 0;
			win        = 1;
			receiving  = 0;
			closed     = 0;
			errors     = 0;
		endfunction

		task report(string msg);
			if (errors < 100)
				$display("%0t ns: %s", $realtime, msg);
			errors++;
		endtask

		function int clamp_count(int v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		function void take_request(req_t r);
			rsp_t                want;
			logic [PAY_BITS-1:0] chunk;
			int                  half;
			want = '0;
			case (r.req_type)
				REQ_START: begin
					bytes_left     = r.file_size;
					receiving      = 1;
					ack_count      = 0;
					win            = 1;
					next_seq       = '0;
					want.ack_valid = 1'b1;
					want.ack_code  = ACK_INFO;
				end
				REQ_DATA: begin
					win       = r.sender_window;
					ack_count = clamp_count(ack_count - 1);
					if (r.packet_seq == next_seq) begin
						if (bytes_left != 0) begin
							chunk            = (bytes_left < payload) ? bytes_left[PAY_BITS-1:0] : payload;
							want.write_bytes = chunk;
							next_seq         = next_seq + 1'b1;
							bytes_left       = bytes_left - chunk;
							ack_count        = clamp_count(ack_count + 1);
							half             = win / 2;
							if (ack_count > half || bytes_left == 0) begin
								want.ack_valid = 1'b1;
								want.ack_code  = ACK_SUCCESS;
								want.ack_seq   = next_seq;
							end
							if (bytes_left == 0 && !closed) begin
								closed             = 1;
								want.transfer_done = 1'b1;
							end
						end else begin
							want.ack_valid = 1'b1;
							want.ack_code  = ACK_SUCCESS;
							want.ack_seq   = r.packet_seq + 1'b1;
							if (!closed) begin
								closed             = 1;
								want.transfer_done = 1'b1;
							end
						end
					end else if (r.packet_seq < next_seq) begin
						want.ack_valid = 1'b1;
						want.ack_code  = ACK_REPEAT;
						want.ack_seq   = next_seq;
					end else begin
						want.ack_valid = 1'b1;
						want.ack_code  = ACK_DUP;
						want.ack_seq   = next_seq;
					end
				end
				REQ_TICK: begin
					if (receiving) begin
						want.ack_valid = 1'b1;
						want.ack_code  = ACK_DUP;
						want.ack_seq   = next_seq;
					end
				end
				default: ;
			endcase
			acks_due.push_back(want);
		endfunction

		task check_ack(rsp_t got);
			rsp_t want;
			if (acks_due.size() == 0) begin
				report($sformatf("word %h popped with nothing due", got));
			end else begin
				want = acks_due.pop_front();
				if (got.ack_valid !== want.ack_valid || got.ack_code !== want.ack_code ||
				    got.ack_seq !== want.ack_seq || got.write_bytes !== want.write_bytes ||
				    got.transfer_done !== want.transfer_done)
					report($sformatf("valid %b/%b code %0d/%0d seq %h/%h bytes %0d/%0d done %b/%b",
						got.ack_valid, want.ack_valid, got.ack_code, want.ack_code,
						got.ack_seq, want.ack_seq, got.write_bytes, want.write_bytes,
						got.transfer_done, want.transfer_done));
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	req_t                 req;
	logic                 empty;
	logic                 pop;
	rsp_t                 rsp;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	ack_board sb;
	int       n_sent;
	int       gap_pct;
	int       stall_pct;
	bit       calm;

	go_back_n_receiver_ack uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.req     (req),
		.empty   (empty),
		.pop     (pop),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic req_t noise();
		req_t r;
		r.req_type      = 2'($urandom);
		r.packet_seq    = $urandom;
		r.sender_window = 16'($urandom);
		r.file_size     = {8'($urandom), 32'($urandom)};
		return r;
	endfunction

	function automatic req_t mk(logic [1:0] kind, logic [SEQ_BITS-1:0] seq,
	                            logic [WIN_BITS-1:0] w, logic [SIZE_BITS-1:0] size);
		req_t r;
		r.req_type      = kind;
		r.packet_seq    = seq;
		r.sender_window = w;
		r.file_size     = size;
		return r;
	endfunction

	function automatic logic [WIN_BITS-1:0] pick_window();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return 16'($urandom_range(1, 8));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	task automatic gap();
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic send_word(req_t r);
		push <= 1'b1;
		req  <= r;
		do @(posedge clk); while (full);
		sb.take_request(r);
		n_sent++;
	endtask

	task automatic settle();
		push <= 1'b0;
		while (sb.acks_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_payload(logic [PAY_BITS-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_PAYLOAD, 2'b00};
		pwdata  <= {{(DATA_BITS-PAY_BITS){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.payload = v;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(DATA_BITS-PAY_BITS){1'b0}}, v})
			sb.report($sformatf("payload_bytes reads %h, wrote %h", prdata, v));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_file();
		req_t                 r;
		int                   k;
		int                   pick;
		logic [SIZE_BITS-1:0] size;
		k = $urandom_range(0, 6);
		if ($urandom_range(0, 9) != 0) begin
			r = noise();
			r.req_type = REQ_START;
			if ($urandom_range(0, 9) != 0) begin
				size = sb.payload * SIZE_BITS'(k);
				size = size + SIZE_BITS'($urandom_range(0, sb.payload - 1));
				r.file_size = size;
			end
			gap();
			send_word(r);
		end
		repeat (k + $urandom_range(1, 4)) begin
			r = noise();
			pick = $urandom_range(0, 99);
			r.req_type = REQ_DATA;
			r.sender_window = pick_window();
			if (pick < 70)
				r.packet_seq = sb.next_seq;
			else if (pick < 80)
				r.packet_seq = (sb.next_seq != 0) ? $urandom_range(0, sb.next_seq - 1) : sb.next_seq;
			else if (pick < 90)
				r.packet_seq = $urandom_range(0, 1) ? sb.next_seq + $urandom_range(1, 3) : $urandom;
			else if (pick < 96)
				r.req_type = REQ_TICK;
			else
				r.req_type = REQ_UNUSED;
			gap();
			send_word(r);
		end
	endtask

	task automatic run_phase(logic [PAY_BITS-1:0] pay, int items);
		int stop;
		settle();
		set_payload(pay);
		gap_pct   = pick_pct();
		stall_pct = pick_pct();
		stop      = n_sent + items;
		while (n_sent < stop) run_file();
	endtask

	initial begin
		int hold;
		hold = 0;
		pop  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_ack(rsp);
			if (hold > 0) begin
				pop <= 1'b0;
				hold--;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				pop  <= 1'b0;
				hold = $urandom_range(0, 6);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		req_t script[$];
		req_t r;
		sb        = new();
		n_sent    = 0;
		gap_pct   = 15;
		stall_pct = 15;
		calm      = 0;
		arst_n    = 1'b0;
		push      = 1'b0;
		req       = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		script.push_back(mk(REQ_TICK, '0, '0, '0));
		script.push_back(mk(REQ_UNUSED, '1, '1, '1));
		script.push_back(mk(REQ_DATA, 32'd7, 16'd4, '0));
		script.push_back(mk(REQ_DATA, '1, '1, '0));
		script.push_back(mk(REQ_START, '1, '1, 40'd1500));
		script.push_back(mk(REQ_DATA, 32'd1, 16'd2, '0));
		script.push_back(mk(REQ_DATA, 32'd0, 16'd2, '1));
		script.push_back(mk(REQ_DATA, 32'd0, 16'd2, '0));
		script.push_back(mk(REQ_TICK, '0, '0, '0));
		script.push_back(mk(REQ_DATA, 32'd1, '1, '0));
		script.push_back(mk(REQ_DATA, 32'd2, '0, '0));
		script.push_back(mk(REQ_DATA, 32'd1, 16'd1, '0));
		script.push_back(mk(REQ_START, '0, '0, '1));
		script.push_back(mk(REQ_DATA, '1, '1, '0));
		script.push_back(mk(REQ_DATA, 32'd0, '0, '0));
		script.push_back(mk(REQ_DATA, 32'd0, '0, '0));
		script.push_back(mk(REQ_TICK, '1, '1, '1));
		script.push_back(mk(REQ_START, '0, '0, '0));
		script.push_back(mk(REQ_DATA, 32'd0, 16'd3, '0));
		script.push_back(mk(REQ_DATA, 32'd0, 16'd3, '0));
		script.push_back(mk(REQ_START, '0, '0, 40'd1024));
		script.push_back(mk(REQ_DATA, 32'd0, 16'd1, '0));
		script.push_back(mk(REQ_DATA, 32'd1, 16'd1, '0));
		script.push_back(mk(REQ_UNUSED, '0, '0, '0));
		foreach (script[i]) begin
			gap();
			send_word(script[i]);
		end

		run_phase(16'd1, 240);
		run_phase(16'hFFFF, 240);
		run_phase(16'($urandom_range(2, 64)), 240);
		run_phase(16'($urandom_range(1, 65535)), 240);
		run_phase(PAYLOAD_RESET, 240);

		// drive the counter negative with a run of future packets
		settle();
		set_payload(16'd2);
		calm = 1;
		send_word(mk(REQ_START, '0, '0, 40'd9));
		repeat (40) begin
			r = noise();
			r.req_type      = REQ_DATA;
			r.packet_seq    = sb.next_seq + 1 + $urandom_range(0, 1000);
			r.sender_window = 16'($urandom_range(0, 3));
			send_word(r);
		end
		repeat (6) send_word(mk(REQ_DATA, sb.next_seq, 16'($urandom_range(0, 3)), '0));
		send_word(mk(REQ_TICK, '0, '0, '0));

		push <= 1'b0;
		while (sb.acks_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.acks_due.size() != 0)
			sb.report($sformatf("%0d words never popped", sb.acks_due.size()));
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- go_back_n_receiver_ack.f -----
rtl/core/gbn_pkg.sv
rtl/core/gbn_queue.sv
rtl/core/gbn_front.sv
rtl/core/gbn_exec.sv
rtl/core/go_back_n_receiver_ack.sv
tb/go_back_n_receiver_ack_test.sv
